[src/chmss_pkg.sv]
// Shared types and constants for the channel marker stream splitter.
`timescale 1ns / 1ps
`default_nettype none
package chmss_pkg;

    localparam int NUM_MARK = 7;
    localparam int WIN_LEN  = 30;
    localparam int CNT_W    = 5;
    localparam int MARK_W   = 8 * WIN_LEN;

    localparam logic OP_TEXT   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic DEST_CONTENT = 1'b0;
    localparam logic DEST_REASON  = 1'b1;

    // marker indexes
    localparam logic [2:0] MK_ANALYSIS   = 3'd0;
    localparam logic [2:0] MK_FINAL      = 3'd1;
    localparam logic [2:0] MK_COMMENTARY = 3'd2;
    localparam logic [2:0] MK_MESSAGE    = 3'd3;
    localparam logic [2:0] MK_END        = 3'd4;
    localparam logic [2:0] MK_RETURN     = 3'd5;
    localparam logic [2:0] MK_START      = 3'd6;

    // marker text, first character in the top byte, zero padded below
    localparam logic [MARK_W-1:0] MARK_TEXT [NUM_MARK] = '{
        {"<|channel|>analysis<|message|>"},
        {"<|channel|>final<|message|>", 24'd0},
        {"<|channel|>commentary", 72'd0},
        {"<|message|>", 152'd0},
        {"<|end|>", 184'd0},
        {"<|return|>", 160'd0},
        {"<|start|>assistant", 96'd0}
    };
    localparam int MARK_LEN [NUM_MARK] = '{30, 27, 21, 11, 7, 10, 18};

    typedef enum logic [4:0] {
        MODE_NORMAL   = 5'b00001,
        MODE_ANALYSIS = 5'b00010,
        MODE_FINAL    = 5'b00100,
        MODE_SCAN     = 5'b01000,
        MODE_COMMENT  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       dest;
        logic       last;
        logic       reason_mode;
    } t_out_req;

    typedef struct packed {
        logic     valid;
        t_out_req req;
    } t_push;

endpackage
`default_nettype wire

[src/channel_marker_stream_splitter.sv]
// Top level of the channel marker stream splitter.
// Splits a byte stream into content and reasoning requests by channel markers. The input
// side stays stalled while a text byte is classified and while the bytes it releases, or
// those a finish flushes, are written out. The front end writes released bytes one per
// cycle into the output queue; it stalls only while that queue is full. Held-back bytes
// live in a 30-byte window, so up to 30 bytes may leave on one item.
`timescale 1ns / 1ps
`default_nettype none
module channel_marker_stream_splitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire chmss_pkg::t_in_req  i_in_req,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output chmss_pkg::t_out_req      o_out_req,
    input  wire logic                i_out_stall
);

    chmss_pkg::t_push push;
    logic             full;

    chmss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .i_full     (full)
    );

    chmss_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

[src/chmss_front.sv]
// Front end: byte window, marker classification and release of bytes into the queue.
`timescale 1ns / 1ps
`default_nettype none
module chmss_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire chmss_pkg::t_in_req i_in_req,
    output logic                    o_in_stall,
    output chmss_pkg::t_push        o_push,
    input  wire logic               i_full
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLASS = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    localparam int NM = chmss_pkg::NUM_MARK;
    localparam int WL = chmss_pkg::WIN_LEN;
    localparam int CW = chmss_pkg::CNT_W;

    t_state           r_state;
    chmss_pkg::t_mode r_mode;
    logic [7:0]       r_win [WL];
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_rd;
    logic [CW-1:0]    r_rel;
    logic [CW-1:0]    r_keep;
    logic             r_dest;

    logic [8*WL-1:0]         w_flat;
    logic [NM-1:0]           full;
    logic [WL-1:0][NM-1:0]   pre;
    logic [NM-1:0]           set_m;
    logic                    sink_on;
    logic                    sink_dest;
    logic                    hit;
    logic [2:0]              best_m;
    logic [CW-1:0]           best_len;
    logic [CW-1:0]           keep;
    logic [CW-1:0]           n_keep;
    logic [CW-1:0]           n_rel;
    chmss_pkg::t_mode        n_mode;

    always_comb begin
        for (int j = 0; j < WL; j++) begin
            w_flat[8*j +: 8] = r_win[j];
        end
    end

    for (genvar m = 0; m < NM; m++) begin : g_mark
        localparam int L = chmss_pkg::MARK_LEN[m];
        assign full[m] = (r_cnt >= CW'(L)) &&
            (w_flat[8*L-1:0] == chmss_pkg::MARK_TEXT[m][chmss_pkg::MARK_W-1 -: 8*L]);
        for (genvar k = 0; k < WL; k++) begin : g_pre
            if (k >= 1 && k < L) begin : g_on
                assign pre[k][m] = (r_cnt >= CW'(k)) &&
                    (w_flat[8*k-1:0] == chmss_pkg::MARK_TEXT[m][chmss_pkg::MARK_W-1 -: 8*k]);
            end else begin : g_off
                assign pre[k][m] = 1'b0;
            end
        end
    end

    always_comb begin
        case (r_mode)
            chmss_pkg::MODE_ANALYSIS: begin
                set_m = 7'b0110000; sink_on = 1'b1; sink_dest = chmss_pkg::DEST_REASON;
            end
            chmss_pkg::MODE_FINAL: begin
                set_m = 7'b0110000; sink_on = 1'b1; sink_dest = chmss_pkg::DEST_CONTENT;
            end
            chmss_pkg::MODE_SCAN: begin
                set_m = 7'b0001011; sink_on = 1'b0; sink_dest = chmss_pkg::DEST_CONTENT;
            end
            chmss_pkg::MODE_COMMENT: begin
                set_m = 7'b0110000; sink_on = 1'b0; sink_dest = chmss_pkg::DEST_CONTENT;
            end
            default: begin
                set_m = 7'b1000111; sink_on = 1'b1; sink_dest = chmss_pkg::DEST_CONTENT;
            end
        endcase
    end

    // longest complete marker wins, since all end on the newest byte
    always_comb begin
        hit      = 1'b0;
        best_m   = chmss_pkg::MK_ANALYSIS;
        best_len = '0;
        for (int m = 0; m < NM; m++) begin
            if (set_m[m] && full[m] && CW'(chmss_pkg::MARK_LEN[m]) > best_len) begin
                hit      = 1'b1;
                best_m   = 3'(m);
                best_len = CW'(chmss_pkg::MARK_LEN[m]);
            end
        end
        keep = '0;
        for (int k = 1; k < WL; k++) begin
            if (|(pre[k] & set_m)) begin
                keep = CW'(k);
            end
        end
        n_keep = hit ? '0 : keep;
        n_rel  = r_cnt - (hit ? best_len : keep);
    end

    always_comb begin
        n_mode = r_mode;
        if (hit) begin
            case (r_mode)
                chmss_pkg::MODE_ANALYSIS,
                chmss_pkg::MODE_FINAL,
                chmss_pkg::MODE_COMMENT: n_mode = chmss_pkg::MODE_NORMAL;
                chmss_pkg::MODE_SCAN: begin
                    if (best_m == chmss_pkg::MK_MESSAGE) begin
                        n_mode = chmss_pkg::MODE_COMMENT;
                    end else if (best_m == chmss_pkg::MK_ANALYSIS) begin
                        n_mode = chmss_pkg::MODE_ANALYSIS;
                    end else begin
                        n_mode = chmss_pkg::MODE_FINAL;
                    end
                end
                default: begin
                    case (best_m)
                        chmss_pkg::MK_ANALYSIS:   n_mode = chmss_pkg::MODE_ANALYSIS;
                        chmss_pkg::MK_FINAL:      n_mode = chmss_pkg::MODE_FINAL;
                        chmss_pkg::MK_COMMENTARY: n_mode = chmss_pkg::MODE_SCAN;
                        default:                  n_mode = chmss_pkg::MODE_NORMAL;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && i_in_req.op == chmss_pkg::OP_TEXT) begin
            r_win[0] <= i_in_req.data_byte;
            for (int j = 1; j < WL; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= chmss_pkg::MODE_NORMAL;
            r_cnt   <= '0;
            r_rel   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_req.op == chmss_pkg::OP_FINISH) begin
                            r_mode <= chmss_pkg::MODE_NORMAL;
                            if (sink_on && r_cnt != '0) begin
                                r_rel   <= r_cnt;
                                r_rd    <= r_cnt - 1'b1;
                                r_keep  <= '0;
                                r_dest  <= sink_dest;
                                r_state <= S_EMIT;
                            end else begin
                                r_cnt <= '0;
                            end
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_CLASS;
                        end
                    end
                end
                S_CLASS: begin
                    r_mode <= n_mode;
                    if (sink_on && n_rel != '0) begin
                        r_rel   <= n_rel;
                        r_rd    <= r_cnt - 1'b1;
                        r_keep  <= n_keep;
                        r_dest  <= sink_dest;
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt   <= n_keep;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!i_full) begin
                        r_rd  <= r_rd - 1'b1;
                        r_rel <= r_rel - 1'b1;
                        if (r_rel == CW'(1)) begin
                            r_cnt   <= r_keep;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall             = (r_state != S_IDLE);
    assign o_push.valid           = (r_state == S_EMIT);
    assign o_push.req.out_byte    = r_win[r_rd];
    assign o_push.req.dest        = r_dest;
    assign o_push.req.last        = (r_rel == CW'(1));
    assign o_push.req.reason_mode = (r_mode == chmss_pkg::MODE_ANALYSIS);

endmodule
`default_nettype wire

[src/chmss_fifo.sv]
// Back end: request queue feeding the output channel.
`timescale 1ns / 1ps
`default_nettype none
module chmss_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire chmss_pkg::t_push    i_push,
    output logic                     o_full,
    output logic                     o_out_valid,
    output chmss_pkg::t_out_req      o_out_req,
    input  wire logic                i_out_stall
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    chmss_pkg::t_out_req r_mem [DEPTH];
    logic [AW-1:0]       r_wr;
    logic [AW-1:0]       r_rd;
    logic [NW-1:0]       r_num;
    logic                wr_en;
    logic                rd_en;

    assign o_full      = (r_num == NW'(DEPTH));
    assign o_out_valid = (r_num != '0);
    assign o_out_req   = r_mem[r_rd];
    assign wr_en       = i_push.valid && !o_full;
    assign rd_en       = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_push.req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_num <= r_num + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_num <= r_num - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/chmss_checker.sv]
// Port-level checks for the channel marker stream splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module chmss_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire chmss_pkg::t_in_req  i_in_req,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire chmss_pkg::t_out_req o_out_req,
    input wire logic                i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_req))
        else $error("output request changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("not idle after reset");

    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_req.op == chmss_pkg::OP_TEXT |=> o_in_stall)
        else $error("text byte not classified before next request");

endmodule

bind channel_marker_stream_splitter chmss_checker u_chk (.*);
`default_nettype wire
